FILE: rtl/uls_pkg.sv
// shared types, constants and decode functions of the utf-8 sanitizer
package uls_pkg;

  localparam logic [7:0] RepByte0 = 8'hEF;
  localparam logic [7:0] RepByte1 = 8'hBF;
  localparam logic [7:0] RepByte2 = 8'hBD;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  // one command from the front: either copy len bytes or emit EF BF BD
  typedef struct packed {
    logic            rep;
    logic [2:0]      len;
    logic [3:0][7:0] bytes;
    logic            run_last;
    logic            stream_end;
  } cmd_t;

  // sequence length from a lead byte, zero for an invalid lead
  function automatic logic [2:0] lead_len(input logic [7:0] c);
    logic [2:0] l;
    if (c[7] == 1'b0)              l = 3'd1;
    else if (c[7:5] == 3'b110)     l = 3'd2;
    else if (c[7:4] == 4'b1110)    l = 3'd3;
    else if (c[7:3] == 5'b11110)   l = 3'd4;
    else                           l = 3'd0;
    return l;
  endfunction

  // check of a complete sequence; w[0] is the lead byte
  function automatic logic seq_ok(input logic [3:0][7:0] w, input logic [2:0] len);
    logic c1;
    logic c2;
    logic c3;
    logic ok;
    c1 = (w[1][7:6] == 2'b10);
    c2 = (w[2][7:6] == 2'b10);
    c3 = (w[3][7:6] == 2'b10);
    case (len)
      3'd1: ok = 1'b1;
      // overlong when the code point is below 0x80, i.e. lead payload bits 4:1 are zero
      3'd2: ok = c1 && (w[0][4:1] != 4'd0);
      // overlong below 0x800, surrogate range D800..DFFF
      3'd3: ok = c1 && c2 && !((w[0][3:0] == 4'd0) && !w[1][5])
                 && !((w[0][3:0] == 4'hD) && w[1][5]);
      // at least 0x10000 and at most 0x10FFFF
      3'd4: ok = c1 && c2 && c3
                 && ((w[0][2:0] != 3'd0) || (w[1][5:4] != 2'd0))
                 && ((w[0][2:0] < 3'd4)
                     || ((w[0][2:0] == 3'd4) && (w[1][5:4] == 2'd0)));
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

FILE: rtl/uls_front.sv
// front end: buffers pending bytes, classifies sequences, issues commands
module uls_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [7:0]    in_byte,
  input  logic          is_last,
  output logic          cmd_push,
  input  logic          cmd_full,
  output uls_pkg::cmd_t cmd
);
  import uls_pkg::*;

  logic            busy;
  logic            busy_next;
  logic [3:0][7:0] hold;
  logic [3:0][7:0] hold_next;
  logic [2:0]      n;
  logic [2:0]      n_next;
  logic [2:0]      pos;
  logic [2:0]      pos_next;
  logic            last;
  logic            last_next;

  logic            accept;
  logic [3:0][7:0] win;
  logic [2:0]      avail;
  logic [2:0]      len;
  logic            brk;
  logic            ok;
  logic [2:0]      adv;
  logic [2:0]      npos;
  logic [2:0]      avail2;
  logic [2:0]      len2;
  logic            brk2;
  logic            rl;
  logic            done;

  assign full   = busy;
  assign accept = push && !busy;

  always_comb begin
    logic [3:0] idx;
    for (int i = 0; i < 4; i++) begin
      idx = {1'b0, pos} + 4'(i);
      win[i] = (idx < 4'd4) ? hold[idx[1:0]] : 8'd0;
    end
  end

  always_comb begin
    avail  = n - pos;
    len    = lead_len(win[0]);
    brk    = (len != 3'd0) && (avail < len) && !last;
    ok     = (len != 3'd0) && (avail >= len) && seq_ok(win, len);
    adv    = ok ? len : 3'd1;
    npos   = pos + adv;
    avail2 = n - npos;
    len2   = (npos < 3'd4) ? lead_len(hold[npos[1:0]]) : 3'd0;
    // results stop after this command when the buffer runs out or waits
    brk2   = (npos != n) && (len2 != 3'd0) && (avail2 < len2) && !last;
    rl     = (npos == n) || brk2;
    done   = (pos == n) || brk;
  end

  always_comb begin
    cmd.rep        = !ok;
    cmd.len        = ok ? len : 3'd3;
    cmd.bytes      = win;
    cmd.run_last   = rl;
    cmd.stream_end = rl && last;
  end

  assign cmd_push = busy && !done && !cmd_full;

  always_comb begin
    busy_next = busy;
    hold_next = hold;
    n_next    = n;
    pos_next  = pos;
    last_next = last;
    if (accept) begin
      hold_next[n[1:0]] = in_byte;
      n_next    = n + 3'd1;
      pos_next  = 3'd0;
      last_next = is_last;
      busy_next = 1'b1;
    end else if (busy && done) begin
      // keep the unfinished tail at the bottom of the buffer
      hold_next = win;
      n_next    = n - pos;
      pos_next  = 3'd0;
      busy_next = 1'b0;
    end else if (cmd_push) begin
      pos_next = npos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      n    <= 3'd0;
      pos  <= 3'd0;
      last <= 1'b0;
    end else begin
      busy <= busy_next;
      n    <= n_next;
      pos  <= pos_next;
      last <= last_next;
    end
    hold <= hold_next;
  end

endmodule

FILE: rtl/uls_fifo.sv
// short command queue between front and back
module uls_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  output logic          full,
  input  uls_pkg::cmd_t wdata,
  input  logic          rd,
  output logic          nonempty,
  output uls_pkg::cmd_t rdata
);
  import uls_pkg::*;

  cmd_t              mem [FifoDepth];
  logic [FifoAw-1:0] wptr;
  logic [FifoAw-1:0] rptr;
  logic [FifoAw:0]   count;
  logic              do_wr;
  logic              do_rd;

  assign full     = (count == (FifoAw + 1)'(FifoDepth));
  assign nonempty = (count != '0);
  assign do_wr    = wr && !full;
  assign do_rd    = rd && nonempty;
  assign rdata    = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) wptr <= wptr + 1'b1;
      if (do_rd) rptr <= rptr + 1'b1;
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
    if (do_wr) mem[wptr] <= wdata;
  end

endmodule

FILE: rtl/uls_back.sv
// back end: expands commands into output bytes, one per transaction
module uls_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_pop,
  input  uls_pkg::cmd_t cmd,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    out_byte,
  output logic          is_replacement,
  output logic          run_last,
  output logic          stream_end
);
  import uls_pkg::*;

  cmd_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       at_end;
  logic       take;

  assign at_end  = ({1'b0, idx} == (cur.len - 3'd1));
  assign take    = !cur_valid || (pop && at_end);
  assign cmd_pop = cmd_valid && take;
  assign empty   = !cur_valid;

  always_comb begin
    if (cur.rep) begin
      case (idx)
        2'd0:    out_byte = RepByte0;
        2'd1:    out_byte = RepByte1;
        default: out_byte = RepByte2;
      endcase
    end else begin
      out_byte = cur.bytes[idx];
    end
    is_replacement = cur.rep;
    run_last       = at_end && cur.run_last;
    stream_end     = at_end && cur.stream_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (take) begin
      cur_valid <= cmd_valid;
      idx       <= 2'd0;
    end else if (pop) begin
      idx <= idx + 2'd1;
    end
    if (take) cur <= cmd;
  end

endmodule

FILE: rtl/utf8_lossy_sanitizer_top.sv
// utf-8 sanitizer top level: front end, command queue and back end
//
// input channel: raw bytes with an end-of-stream mark, written like a queue
// (push while full is low). result channel: sanitized bytes, read like a
// queue (out fields valid while empty is low, pop takes one).
// each input byte is buffered with up to three earlier pending bytes; the
// front end then resolves one sequence or one replacement per cycle while
// the command queue has room, and at the end stores the unfinished tail.
// full stays high while that runs. the back end emits one byte per cycle
// while pop is high and empty is low, from its current command (1..4
// copied bytes, or EF BF BD for a replacement); a result is registered in
// the command queue and then in the back end before it shows. a four-entry
// command queue lets the front keep working while the reader stalls; when
// the queue fills the front end waits with full held high. run_last marks
// the last byte caused by an input byte, stream_end the last byte of a
// stream; after a byte marked last the buffer is empty. reset drops the
// buffer, the queue and any waiting result.
module utf8_lossy_sanitizer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       is_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       is_replacement,
  output logic       run_last,
  output logic       stream_end
);
  import uls_pkg::*;

  cmd_t cmd_in;
  cmd_t cmd_out;
  logic cmd_push;
  logic cmd_full;
  logic cmd_valid;
  logic cmd_pop;

  uls_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_byte  (in_byte),
    .is_last  (is_last),
    .cmd_push (cmd_push),
    .cmd_full (cmd_full),
    .cmd      (cmd_in)
  );

  uls_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr       (cmd_push),
    .full     (cmd_full),
    .wdata    (cmd_in),
    .rd       (cmd_pop),
    .nonempty (cmd_valid),
    .rdata    (cmd_out)
  );

  uls_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd_pop        (cmd_pop),
    .cmd            (cmd_out),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .is_replacement (is_replacement),
    .run_last       (run_last),
    .stream_end     (stream_end)
  );

endmodule

FILE: tb/tb_utf8_lossy_sanitizer_top.sv
// testbench of the utf-8 sanitizer: directed table and random byte streams against a predictor
`timescale 1ns / 1ps

module tb_utf8_lossy_sanitizer_top;

  localparam int unsigned DirRows       = 25;
  localparam int unsigned RandItems     = 345;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned TailCycles    = 20;

  localparam logic [7:0] ReplB0 = 8'hEF;
  localparam logic [7:0] ReplB1 = 8'hBF;
  localparam logic [7:0] ReplB2 = 8'hBD;

  typedef enum logic [1:0] {
    RowPredict,
    RowCopy,
    RowRepl
  } row_kind_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    row_kind_t  kind;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] b;
    logic       rep;
    logic       run_last;
    logic       stream_end;
  } san_byte_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } raw_byte_t;

  // typed rows: plain ascii copies and bad leads on an empty buffer, and predicted multi-byte cases
  localparam dir_row_t DirTable [DirRows] = '{
    '{8'h00, 1'b0, RowCopy},    // ascii low extreme right after reset
    '{8'h7F, 1'b0, RowCopy},
    '{8'h80, 1'b0, RowRepl},    // lone continuation as lead
    '{8'hFF, 1'b0, RowRepl},    // 11111xxx lead
    '{8'hC2, 1'b0, RowPredict}, // valid two-byte with the smallest valid lead
    '{8'hA9, 1'b0, RowPredict},
    '{8'hC0, 1'b0, RowPredict}, // overlong two-byte
    '{8'h80, 1'b0, RowPredict},
    '{8'hE0, 1'b0, RowPredict}, // smallest valid three-byte
    '{8'hA0, 1'b0, RowPredict},
    '{8'h80, 1'b0, RowPredict},
    '{8'hED, 1'b0, RowPredict}, // surrogate
    '{8'hA0, 1'b0, RowPredict},
    '{8'h80, 1'b0, RowPredict},
    '{8'hF4, 1'b0, RowPredict}, // just above the top code point
    '{8'h90, 1'b0, RowPredict},
    '{8'h80, 1'b0, RowPredict},
    '{8'h80, 1'b0, RowPredict},
    '{8'hF5, 1'b0, RowPredict}, // lead that always decodes too high
    '{8'h80, 1'b0, RowPredict},
    '{8'h80, 1'b0, RowPredict},
    '{8'h80, 1'b0, RowPredict},
    '{8'hE2, 1'b0, RowPredict}, // truncated at end of stream
    '{8'h82, 1'b1, RowPredict},
    '{8'h41, 1'b1, RowCopy}     // last byte with an empty buffer
  };

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] in_byte;
  logic       is_last;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte;
  logic       is_replacement;
  logic       run_last;
  logic       stream_end;

  utf8_lossy_sanitizer_top uut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .in_byte       (in_byte),
    .is_last       (is_last),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .is_replacement(is_replacement),
    .run_last      (run_last),
    .stream_end    (stream_end)
  );

  // predictor state: bytes of an unfinished sequence
  logic [7:0]  held_bytes [3];
  int unsigned held_cnt;

  san_byte_t   expected_q [$];
  san_byte_t   step_q [$];
  raw_byte_t   stream_q [$];
  row_kind_t   cur_kind;
  int unsigned err_cnt;
  int unsigned quiet_cnt;
  bit          tx_idle;
  bit          rx_idle;
  bit          hold_req;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    err_cnt++;
  endtask

  function automatic int unsigned lead_size(input logic [7:0] c);
    if (c < 8'h80) return 1;
    if (c >= 8'hC0 && c < 8'hE0) return 2;
    if (c >= 8'hE0 && c < 8'hF0) return 3;
    if (c >= 8'hF0 && c < 8'hF8) return 4;
    return 0;
  endfunction

  // full decode of a complete sequence to its code point, then range checks
  function automatic bit seq_valid(input logic [7:0] b0, input logic [7:0] b1,
                                   input logic [7:0] b2, input logic [7:0] b3,
                                   input int unsigned len);
    logic [20:0] cp;
    if (len >= 2 && b1[7:6] != 2'b10) return 1'b0;
    if (len >= 3 && b2[7:6] != 2'b10) return 1'b0;
    if (len >= 4 && b3[7:6] != 2'b10) return 1'b0;
    case (len)
      1: return 1'b1;
      2: begin
        cp = 21'({b0[4:0], b1[5:0]});
        return cp >= 21'h80;
      end
      3: begin
        cp = 21'({b0[3:0], b1[5:0], b2[5:0]});
        return cp >= 21'h800 && !(cp >= 21'hD800 && cp <= 21'hDFFF);
      end
      4: begin
        cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
        return cp >= 21'h10000 && cp <= 21'h10FFFF;
      end
      default: return 1'b0;
    endcase
  endfunction

  // works out the output bytes of one accepted input byte into step_q
  task automatic sanitize_byte(input logic [7:0] b, input logic last);
    logic [7:0]  win [0:6];
    int unsigned n;
    int unsigned pos;
    int unsigned len;
    int unsigned i;
    san_byte_t   tail;
    for (i = 0; i < 7; i++) win[i] = 8'h00;
    n = held_cnt;
    for (i = 0; i < n; i++) win[i] = held_bytes[i];
    win[n] = b;
    n++;
    pos = 0;
    step_q.delete();
    while (pos < n) begin
      len = lead_size(win[pos]);
      if (len != 0 && n - pos < len && !last) break;
      if (len != 0 && n - pos >= len &&
          seq_valid(win[pos], win[pos+1], win[pos+2], win[pos+3], len)) begin
        for (i = 0; i < len; i++) step_q.push_back('{win[pos+i], 1'b0, 1'b0, 1'b0});
        pos += len;
      end else begin
        step_q.push_back('{ReplB0, 1'b1, 1'b0, 1'b0});
        step_q.push_back('{ReplB1, 1'b1, 1'b0, 1'b0});
        step_q.push_back('{ReplB2, 1'b1, 1'b0, 1'b0});
        pos += 1;
      end
    end
    held_cnt = n - pos;
    for (i = 0; i < held_cnt; i++) held_bytes[i] = win[pos+i];
    if (step_q.size() > 0) begin
      tail = step_q.pop_back();
      tail.run_last = 1'b1;
      tail.stream_end = last;
      step_q.push_back(tail);
    end
  endtask

  // transaction monitor, prediction and checking
  always @(posedge clk) begin : monitor
    san_byte_t got;
    san_byte_t want;
    bit        moved;
    if (!rst) begin
      moved = 1'b0;
      if (push && !full) begin
        moved = 1'b1;
        sanitize_byte(in_byte, is_last);
        if (cur_kind == RowCopy) begin
          step_q.delete();
          step_q.push_back('{in_byte, 1'b0, 1'b1, is_last});
        end else if (cur_kind == RowRepl) begin
          step_q.delete();
          step_q.push_back('{ReplB0, 1'b1, 1'b0, 1'b0});
          step_q.push_back('{ReplB1, 1'b1, 1'b0, 1'b0});
          step_q.push_back('{ReplB2, 1'b1, 1'b1, is_last});
        end
        foreach (step_q[k]) expected_q.push_back(step_q[k]);
      end
      if (pop && !empty) begin
        moved = 1'b1;
        got = '{out_byte, is_replacement, run_last, stream_end};
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result byte %02h rep %0b rl %0b se %0b",
                                    got.b, got.rep, got.run_last, got.stream_end));
        end else begin
          want = expected_q.pop_front();
          if (got.b !== want.b || got.rep !== want.rep ||
              got.run_last !== want.run_last || got.stream_end !== want.stream_end) begin
            report_mismatch($sformatf(
              "got byte %02h rep %0b rl %0b se %0b, want %02h rep %0b rl %0b se %0b",
              got.b, got.rep, got.run_last, got.stream_end,
              want.b, want.rep, want.run_last, want.stream_end));
          end
        end
      end
      if (moved) begin
        quiet_cnt = 0;
      end else begin
        quiet_cnt++;
        if (quiet_cnt >= WatchdogLimit) begin
          $display("timeout: no transaction for %0d cycles", quiet_cnt);
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  task automatic add_raw(input logic [7:0] b);
    stream_q.push_back('{b, 1'b0});
  endtask

  task automatic add_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      add_raw(cp[7:0]);
    end else if (cp < 21'h800) begin
      add_raw({3'b110, cp[10:6]});
      add_raw({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      add_raw({4'b1110, cp[15:12]});
      add_raw({2'b10, cp[11:6]});
      add_raw({2'b10, cp[5:0]});
    end else begin
      add_raw({5'b11110, cp[20:18]});
      add_raw({2'b10, cp[17:12]});
      add_raw({2'b10, cp[11:6]});
      add_raw({2'b10, cp[5:0]});
    end
  endtask

  // one sequence of the random stream: mostly well formed, some broken
  task automatic add_sequence();
    int unsigned sel;
    int unsigned n0;
    int unsigned len;
    logic [20:0] cp;
    logic [20:0] edges [11];
    edges = '{21'h0, 21'h7F, 21'h80, 21'h7FF, 21'h800, 21'hD7FF, 21'hE000,
              21'hFFFD, 21'hFFFF, 21'h10000, 21'h10FFFF};
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      add_raw(8'($urandom_range(0, 127)));
    end else if (sel < 50) begin
      add_code_point(21'($urandom_range(32'h80, 32'h7FF)));
    end else if (sel < 63) begin
      cp = 21'($urandom_range(32'h800, 32'hFFFF));
      if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h2000;
      add_code_point(cp);
    end else if (sel < 73) begin
      add_code_point(21'($urandom_range(32'h10000, 32'h10FFFF)));
    end else if (sel < 80) begin
      add_code_point(edges[$urandom_range(0, 10)]);
    end else begin
      case ($urandom_range(0, 9))
        0: add_raw(cont_byte());
        1: add_raw(8'($urandom_range(8'hF8, 8'hFF)));
        2: begin
          // overlong two-byte
          add_raw(8'($urandom_range(8'hC0, 8'hC1)));
          add_raw(cont_byte());
        end
        3: begin
          add_raw(8'hE0);
          add_raw(8'($urandom_range(8'h80, 8'h9F)));
          add_raw(cont_byte());
        end
        4: begin
          // surrogate half
          add_raw(8'hED);
          add_raw(8'($urandom_range(8'hA0, 8'hBF)));
          add_raw(cont_byte());
        end
        5: begin
          if ($urandom_range(0, 1)) begin
            add_raw(8'hF0);
            add_raw(8'($urandom_range(8'h80, 8'h8F)));
          end else begin
            add_raw(8'hF4);
            add_raw(8'($urandom_range(8'h90, 8'hBF)));
          end
          add_raw(cont_byte());
          add_raw(cont_byte());
        end
        6: begin
          add_raw(8'($urandom_range(8'hF5, 8'hF7)));
          add_raw(cont_byte());
          add_raw(cont_byte());
          add_raw(cont_byte());
        end
        7: begin
          // truncated valid sequence, the next sequence breaks in
          n0 = stream_q.size();
          add_code_point(21'($urandom_range(32'h80, 32'h10FFFF)));
          len = stream_q.size() - n0;
          repeat ($urandom_range(1, len - 1)) void'(stream_q.pop_back());
        end
        8: begin
          // lead followed by a random second byte, which may or may not be a continuation
          add_raw(8'($urandom_range(8'hC2, 8'hF4)));
          add_raw(8'($urandom_range(0, 127)) | (8'($urandom_range(0, 1)) << 7 & 8'hC0));
        end
        default: add_raw(8'($urandom()));
      endcase
    end
  endtask

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_byte(input logic [7:0] b, input logic last, input row_kind_t kind);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push     <= 1'b1;
    in_byte  <= b;
    is_last  <= last;
    cur_kind = kind;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  // result side
  initial begin : reader
    int unsigned gap;
    pop = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        // long hold-off so the block fills and stalls its input
        pop <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end
      gap = rx_idle ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      @(negedge clk);
    end
  end

  // input side and end of run
  initial begin : writer
    int unsigned sent;
    int unsigned mode;
    raw_byte_t   item;
    rst        = 1'b1;
    push       = 1'b0;
    in_byte    = 8'h00;
    is_last    = 1'b0;
    cur_kind   = RowPredict;
    held_cnt   = 0;
    held_bytes = '{8'h00, 8'h00, 8'h00};
    err_cnt    = 0;
    quiet_cnt  = 0;
    tx_idle    = 1'b1;
    rx_idle    = 1'b1;
    hold_req   = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DirRows; i++) begin
      send_byte(DirTable[i].b, DirTable[i].last, DirTable[i].kind);
    end

    sent = 0;
    while (sent < RandItems) begin
      if (sent % 40 == 0) begin
        mode = $urandom_range(0, 3);
        tx_idle = mode[0];
        rx_idle = mode[1];
      end
      if (sent == 121) begin
        tx_idle  = 1'b0;
        hold_req = 1'b1;
      end
      if (sent == 240) begin
        push <= 1'b0;
        @(negedge clk);
        wait_drained();
      end
      if (stream_q.size() == 0) add_sequence();
      item = stream_q.pop_front();
      item.last = ($urandom_range(0, 29) == 0) ||
                  (stream_q.size() == 0 && $urandom_range(0, 7) == 0) ||
                  (sent == RandItems - 1);
      send_byte(item.b, item.last, RowPredict);
      sent++;
    end
    push <= 1'b0;

    wait_drained();
    repeat (TailCycles) @(negedge clk);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/uls_pkg.sv
rtl/uls_front.sv
rtl/uls_fifo.sv
rtl/uls_back.sv
rtl/utf8_lossy_sanitizer_top.sv
tb/tb_utf8_lossy_sanitizer_top.sv
